// File: src/base64_decoder_assert.svh
// Assertion macros used by the base64 decoder port checker
`ifndef BASE64_DECODER_ASSERT_SVH
`define BASE64_DECODER_ASSERT_SVH

// Same-cycle implication, inactive while reset is asserted
`define B64D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64d assertion failed");

// Next-cycle implication, inactive while reset is asserted
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64d assertion failed");

`endif

// File: src/b64d_pkg.sv
// Types, constants and decode functions of the base64 decoder
package b64d_pkg;

  localparam int B64D_QDEPTH = 4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;
  } b64d_out_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
  } b64d_beat_t;

  typedef struct packed {
    b64d_beat_t [2:0] beat;
    logic [1:0]       last_idx;
  } b64d_cmd_t;

  // Bit 6 set marks a character outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = 7'h40;
    if (c inside {[8'h41:8'h5a]}) begin
      v = 7'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7a]}) begin
      v = 7'(c - 8'd71);
    end else if (c inside {[8'h30:8'h39]}) begin
      v = 7'(c + 8'd4);
    end else if (c == 8'h2b) begin
      v = 7'd62;
    end else if (c == 8'h2f) begin
      v = 7'd63;
    end
    return v;
  endfunction

  function automatic b64d_beat_t data_beat(input logic [7:0] b, input logic fin);
    b64d_beat_t r;
    r.data_byte   = b;
    r.byte_valid  = 1'b1;
    r.message_end = fin;
    return r;
  endfunction

  function automatic b64d_beat_t marker_beat();
    b64d_beat_t r;
    r.data_byte   = 8'h00;
    r.byte_valid  = 1'b0;
    r.message_end = 1'b1;
    return r;
  endfunction

  // Release k-1 known bytes of a partial group (none for k below two), then the end marker
  function automatic b64d_cmd_t flush_cmd(input logic [5:0] h0, input logic [5:0] h1,
                                          input logic [5:0] h2, input logic [1:0] k);
    b64d_cmd_t r;
    r = '0;
    case (k)
      2'd2: begin
        r.beat[0]  = data_beat({h0, h1[5:4]}, 1'b0);
        r.beat[1]  = marker_beat();
        r.last_idx = 2'd1;
      end
      2'd3: begin
        r.beat[0]  = data_beat({h0, h1[5:4]}, 1'b0);
        r.beat[1]  = data_beat({h1[3:0], h2[5:2]}, 1'b0);
        r.beat[2]  = marker_beat();
        r.last_idx = 2'd2;
      end
      default: begin
        r.beat[0]  = marker_beat();
        r.last_idx = 2'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// File: src/b64d_front.sv
// Front end: accepts characters, tracks the open group, emits byte commands
module b64d_front
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_acc,
  input  b64d_in_t  in_data,
  output logic      cmd_push,
  output b64d_cmd_t cmd
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       stopped_r, stopped_nxt;
  logic [5:0] held_r [3];
  logic [5:0] held_nxt [3];
  logic [6:0] sx;

  assign sx = sextet_of(in_data.char_code);

  always_comb begin
    cnt_nxt     = cnt_r;
    stopped_nxt = stopped_r;
    held_nxt    = held_r;
    cmd_push    = 1'b0;
    cmd         = '0;
    if (in_acc) begin
      if (stopped_r) begin
        if (in_data.final_char) begin
          stopped_nxt = 1'b0;
          cnt_nxt     = 2'd0;
        end
      end else if (sx[6]) begin
        cmd         = flush_cmd(held_r[0], held_r[1], held_r[2], cnt_r);
        cmd_push    = 1'b1;
        cnt_nxt     = 2'd0;
        stopped_nxt = !in_data.final_char;
      end else if (cnt_r == 2'd3) begin
        cmd.beat[0]  = data_beat({held_r[0], held_r[1][5:4]}, 1'b0);
        cmd.beat[1]  = data_beat({held_r[1][3:0], held_r[2][5:2]}, 1'b0);
        cmd.beat[2]  = data_beat({held_r[2][1:0], sx[5:0]}, in_data.final_char);
        cmd.last_idx = 2'd2;
        cmd_push     = 1'b1;
        cnt_nxt      = 2'd0;
      end else begin
        held_nxt[cnt_r] = sx[5:0];
        cnt_nxt         = cnt_r + 2'd1;
        if (in_data.final_char) begin
          cmd      = flush_cmd(held_nxt[0], held_nxt[1], held_nxt[2], cnt_r + 2'd1);
          cmd_push = 1'b1;
          cnt_nxt  = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 2'd0;
      stopped_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

// File: src/b64d_cmdq.sv
// Command queue between the front end and the result sequencer
module b64d_cmdq
  import b64d_pkg::*;
#(
  parameter int QDEPTH = B64D_QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  b64d_cmd_t wr_data,
  output logic      q_full,
  input  logic      rd_en,
  output logic      q_empty,
  output b64d_cmd_t rd_data
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  b64d_cmd_t      mem_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_wr, do_rd;

  assign q_full  = (cnt_r == CW'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: src/b64d_back.sv
// Back end: steps through each command and presents one result beat at a time
module b64d_back
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  b64d_cmd_t q_data,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output b64d_out_t out_data
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  b64d_out_t  out_r, out_nxt;
  logic       load, at_last;

  assign load    = !vld_r || pop;
  assign at_last = (idx_r == q_data.last_idx);

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    out_nxt = out_r;
    q_pop   = 1'b0;
    if (load) begin
      vld_nxt = !q_empty;
      if (!q_empty) begin
        out_nxt.data_byte   = q_data.beat[idx_r].data_byte;
        out_nxt.byte_valid  = q_data.beat[idx_r].byte_valid;
        out_nxt.message_end = q_data.beat[idx_r].message_end;
        out_nxt.run_last    = at_last;
        q_pop               = at_last;
        idx_nxt             = at_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign empty    = !vld_r;
  assign out_data = out_r;

endmodule

// File: src/base64_decoder.sv
// Base64 decoder top level: front end, command queue, result sequencer
//
//   channel   handshake        payload
//   input     push / full      in_data  (char_code, final_char)
//   result    pop / empty      out_data (data_byte, byte_valid, run_last, message_end)
//
// One character is accepted per cycle while the command queue has room.
// Results leave one beat per cycle while pop is given; an item makes zero to three
// beats, set by its command; the result sequencer steps through the head command
// one beat per cycle while its output is empty or popped, registering each beat.
// Reset (rst_n low, synchronous) empties the queue and clears the open group.
// A stalled result side fills the QDEPTH-entry queue, then raises full.
module base64_decoder
  import b64d_pkg::*;
#(
  parameter int QDEPTH = B64D_QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  b64d_in_t  in_data,
  input  logic      pop,
  output logic      empty,
  output b64d_out_t out_data
);

  logic      in_acc;
  logic      cmd_push;
  b64d_cmd_t cmd;
  logic      q_full, q_empty, q_pop;
  b64d_cmd_t q_data;

  assign full   = q_full;
  assign in_acc = push && !q_full;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_data  (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  b64d_cmdq #(
    .QDEPTH (QDEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_data (q_data)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// File: src/b64d_port_chk.sv
// Port-level checker for the base64 decoder and its bind
`include "base64_decoder_assert.svh"

module b64d_port_chk
  import b64d_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      pop,
  input logic      empty,
  input b64d_out_t out_data
);

  `B64D_ASSERT_NOW(a_reset_idle, clk, rst_n, $past(!rst_n), empty && !full)
  `B64D_ASSERT_NEXT(a_beat_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_data))
  `B64D_ASSERT_NOW(a_marker_shape, clk, rst_n, !empty && !out_data.byte_valid, out_data.message_end && out_data.run_last && (out_data.data_byte == 8'h00))
  `B64D_ASSERT_NOW(a_end_closes_run, clk, rst_n, !empty && out_data.message_end, out_data.run_last)

endmodule

bind base64_decoder b64d_port_chk u_port_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .pop      (pop),
  .empty    (empty),
  .out_data (out_data)
);
